// ----- rtl/btlpm_pkg.sv -----
// Shared types and codes for the binary trie longest prefix match block.
`default_nettype none
package btlpm_pkg;

   localparam int NODE_BITS  = 12;
   localparam int NODES      = 4096;
   localparam int VALUE_BITS = 16;
   localparam int COUNT_BITS = 13;
   localparam logic [6:0] KEY_MAX_BITS = 7'd64;

   typedef logic [NODE_BITS-1:0] node_idx_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  has_value;
      node_idx_type          parent;
      node_idx_type          child0;
      node_idx_type          child1;
   } node_type;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_LEN   = 3'd1;
   localparam logic [2:0] ST_EXISTS    = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_POOL_FULL = 3'd4;

   localparam logic REG_KEY_BITS      = 1'b0;
   localparam logic REG_DEFAULT_VALUE = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WALK_RD,
      S_WALK,
      S_ALLOC_POP,
      S_ALLOC_LINK,
      S_ALLOC_FIN,
      S_PRUNE_RD,
      S_PRUNE
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/binary_trie_longest_prefix_match.sv -----
// Top level: binary trie longest prefix match with add, remove and lookup.
// Usage:
//  - Input beat: raise start with req_* while busy is low; the beat is taken
//    at that edge. Commands answered at once leave busy low; the others hold
//    busy high until the strobe.
//  - Result beat: rsp_strobe is high for one cycle with rsp_status and
//    rsp_match_value; the receiver cannot hold it off.
//  - Configuration: csr_write_enable with csr_index (0 key width, 1 default
//    value) and csr_write_data, only while busy is low.
//  - Flow: invalid, zero-length and unused commands are answered straight from
//    the idle state. Lookup and the descent of add/remove visit one trie level
//    per node memory read (a read state, then a walk state). Add then pops the
//    free list and links the parent for each created node, and writes the value
//    last; remove climbs one level per read and prune step while pruning.
//  - busy is low in the strobe cycle; the next beat may be taken at the edge
//    that ends it.
//  - Reset: the trie is empty, root holds the default value, all other nodes
//    are free; no clearing pass is needed, memories start unwritten.
`default_nettype none
module binary_trie_longest_prefix_match (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [63:0] req_key,
   input  wire logic [6:0]  req_prefix_length,
   input  wire logic [15:0] req_entry_value,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic signed [16:0] rsp_match_value,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [16:0] csr_write_data
);

   btlpm_pkg::state_type state_ff, state_in;
   logic [6:0]  key_bits_ff;
   logic signed [16:0] default_ff;
   btlpm_pkg::node_type root_ff, root_in;
   btlpm_pkg::node_type cur_ff, cur_in;
   btlpm_pkg::node_idx_type idx_ff, idx_in, prev_ff, prev_in;
   logic [6:0]  depth_ff, depth_in, len_ff, len_in;
   logic [1:0]  op_ff, op_in;
   logic [63:0] key_ff, key_in;
   logic [15:0] val_ff, val_in;
   logic signed [16:0] best_ff, best_in;
   logic        strobe_ff, strobe_in;
   logic [2:0]  status_ff, status_in;
   logic signed [16:0] match_ff, match_in;

   logic [6:0]  kb, need;
   logic signed [16:0] root_val, best_next;
   btlpm_pkg::node_type cur, nw_data;
   btlpm_pkg::node_idx_type nw_idx, child, fresh;
   logic        nw_en, bit_sel, child_nz, lt_len, at_end, kids, one_kid;
   logic        advance, pool_short, alloc_go, prune_go, prune_more, last;
   logic        fl_pop, fl_push;
   logic [btlpm_pkg::COUNT_BITS-1:0] free_count;
   btlpm_pkg::node_type ram_rdata;
   logic        ram_re, bad_len;

   btlpm_node_ram u_node_ram (
      .clock   (clock),
      .wr_en   (nw_en && (nw_idx != '0)),
      .wr_addr (nw_idx),
      .wr_data (nw_data),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   btlpm_free_list u_free_list (
      .clock     (clock),
      .reset     (reset),
      .pop       (fl_pop),
      .push      (fl_push),
      .push_data (idx_ff),
      .pop_data  (fresh),
      .count     (free_count)
   );

   assign kb       = (key_bits_ff > btlpm_pkg::KEY_MAX_BITS) ? btlpm_pkg::KEY_MAX_BITS
                                                            : key_bits_ff;
   assign root_val = root_ff.has_value ? $signed({1'b0, root_ff.value}) : default_ff;
   assign cur      = (idx_ff == '0) ? root_ff : ram_rdata;
   assign bit_sel  = key_ff[~depth_ff[5:0]];
   assign child    = bit_sel ? cur.child1 : cur.child0;
   assign child_nz = child != '0;
   assign lt_len   = depth_ff < len_ff;
   assign at_end   = depth_ff == len_ff;
   assign kids     = (cur.child0 != '0) || (cur.child1 != '0);
   assign one_kid  = (cur.child0 != '0) ^ (cur.child1 != '0);
   assign advance  = (op_ff == btlpm_pkg::CMD_LOOKUP) ? ((depth_ff < kb) && child_nz)
                                                      : (lt_len && child_nz);
   assign need       = len_ff - depth_ff;
   assign pool_short = free_count < {6'd0, need};
   assign alloc_go   = (op_ff == btlpm_pkg::CMD_ADD) && !advance && lt_len && !pool_short;
   assign prune_go   = (op_ff == btlpm_pkg::CMD_REMOVE) && !advance && at_end &&
                       cur.has_value && !kids;
   assign prune_more = (idx_ff != '0) && !cur.has_value && one_kid;
   assign last       = (depth_ff + 7'd1) == len_ff;
   assign best_next  = ((idx_ff != '0) && cur.has_value) ? $signed({1'b0, cur.value})
                                                         : best_ff;
   assign bad_len    = req_prefix_length > kb;
   assign ram_re     = (state_ff == btlpm_pkg::S_WALK_RD) ||
                       (state_ff == btlpm_pkg::S_PRUNE_RD);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         btlpm_pkg::S_IDLE: begin
            if (start) begin
               if ((req_command == btlpm_pkg::CMD_ADD) ||
                   (req_command == btlpm_pkg::CMD_REMOVE)) begin
                  if (!bad_len && (req_prefix_length != 7'd0)) begin
                     state_in = btlpm_pkg::S_WALK_RD;
                  end
               end else if (req_command == btlpm_pkg::CMD_LOOKUP) begin
                  state_in = btlpm_pkg::S_WALK_RD;
               end
            end
         end
         btlpm_pkg::S_WALK_RD:  state_in = btlpm_pkg::S_WALK;
         btlpm_pkg::S_WALK: begin
            if (advance) begin
               state_in = btlpm_pkg::S_WALK_RD;
            end else if (alloc_go) begin
               state_in = btlpm_pkg::S_ALLOC_POP;
            end else if (prune_go) begin
               state_in = btlpm_pkg::S_PRUNE_RD;
            end else begin
               state_in = btlpm_pkg::S_IDLE;
            end
         end
         btlpm_pkg::S_ALLOC_POP:  state_in = btlpm_pkg::S_ALLOC_LINK;
         btlpm_pkg::S_ALLOC_LINK: state_in = last ? btlpm_pkg::S_ALLOC_FIN
                                                  : btlpm_pkg::S_ALLOC_POP;
         btlpm_pkg::S_ALLOC_FIN:  state_in = btlpm_pkg::S_IDLE;
         btlpm_pkg::S_PRUNE_RD:   state_in = btlpm_pkg::S_PRUNE;
         btlpm_pkg::S_PRUNE:      state_in = prune_more ? btlpm_pkg::S_PRUNE_RD
                                                        : btlpm_pkg::S_IDLE;
         default:                 state_in = btlpm_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      root_in   = root_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      prev_in   = prev_ff;
      depth_in  = depth_ff;
      len_in    = len_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      best_in   = best_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      match_in  = match_ff;
      nw_en     = 1'b0;
      nw_idx    = idx_ff;
      nw_data   = cur;
      fl_pop    = 1'b0;
      fl_push   = 1'b0;
      unique case (state_ff)
         btlpm_pkg::S_IDLE: begin
            if (start) begin
               op_in    = req_command;
               key_in   = req_key;
               len_in   = req_prefix_length;
               val_in   = req_entry_value;
               idx_in   = '0;
               depth_in = 7'd0;
               best_in  = root_val;
               match_in = '0;
               status_in = btlpm_pkg::ST_OK;
               case (req_command)
                  btlpm_pkg::CMD_ADD: begin
                     if (bad_len) begin
                        strobe_in = 1'b1;
                        status_in = btlpm_pkg::ST_BAD_LEN;
                     end else if (req_prefix_length == 7'd0) begin
                        strobe_in = 1'b1;
                        if (root_val != default_ff) begin
                           status_in = btlpm_pkg::ST_EXISTS;
                        end else begin
                           root_in.has_value = 1'b1;
                           root_in.value     = req_entry_value;
                        end
                     end
                  end
                  btlpm_pkg::CMD_REMOVE: begin
                     if (bad_len) begin
                        strobe_in = 1'b1;
                        status_in = btlpm_pkg::ST_BAD_LEN;
                     end else if (req_prefix_length == 7'd0) begin
                        strobe_in = 1'b1;
                        root_in.has_value = 1'b0;
                        root_in.value     = '0;
                     end
                  end
                  btlpm_pkg::CMD_LOOKUP: begin
                  end
                  default: strobe_in = 1'b1;
               endcase
            end
         end
         btlpm_pkg::S_WALK: begin
            cur_in  = cur;
            best_in = best_next;
            if (advance) begin
               idx_in   = child;
               depth_in = depth_ff + 7'd1;
            end else begin
               case (op_ff)
                  btlpm_pkg::CMD_LOOKUP: begin
                     strobe_in = 1'b1;
                     match_in  = best_next;
                  end
                  btlpm_pkg::CMD_ADD: begin
                     if (at_end) begin
                        strobe_in = 1'b1;
                        if (cur.has_value) begin
                           status_in = btlpm_pkg::ST_EXISTS;
                        end else begin
                           nw_en             = 1'b1;
                           nw_data.has_value = 1'b1;
                           nw_data.value     = val_ff;
                        end
                     end else if (pool_short) begin
                        strobe_in = 1'b1;
                        status_in = btlpm_pkg::ST_POOL_FULL;
                     end
                  end
                  default: begin
                     if (!at_end || !cur.has_value) begin
                        strobe_in = 1'b1;
                        status_in = btlpm_pkg::ST_NOT_FOUND;
                     end else if (kids) begin
                        strobe_in         = 1'b1;
                        nw_en             = 1'b1;
                        nw_data.has_value = 1'b0;
                        nw_data.value     = '0;
                     end else begin
                        fl_push = 1'b1;
                        prev_in = idx_ff;
                        idx_in  = cur.parent;
                     end
                  end
               endcase
            end
         end
         btlpm_pkg::S_PRUNE: begin
            if (prune_more) begin
               fl_push = 1'b1;
               prev_in = idx_ff;
               idx_in  = cur.parent;
            end else begin
               strobe_in = 1'b1;
               nw_en     = 1'b1;
               if (cur.child0 == prev_ff) begin
                  nw_data.child0 = '0;
               end else begin
                  nw_data.child1 = '0;
               end
            end
         end
         btlpm_pkg::S_ALLOC_POP: begin
            fl_pop = 1'b1;
         end
         btlpm_pkg::S_ALLOC_LINK: begin
            nw_en   = 1'b1;
            nw_data = cur_ff;
            if (bit_sel) begin
               nw_data.child1 = fresh;
            end else begin
               nw_data.child0 = fresh;
            end
            cur_in        = '0;
            cur_in.parent = idx_ff;
            idx_in        = fresh;
            depth_in      = depth_ff + 7'd1;
         end
         btlpm_pkg::S_ALLOC_FIN: begin
            strobe_in         = 1'b1;
            nw_en             = 1'b1;
            nw_data           = cur_ff;
            nw_data.has_value = 1'b1;
            nw_data.value     = val_ff;
         end
         default: begin
         end
      endcase
      if (nw_en && (nw_idx == '0)) begin
         root_in = nw_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= btlpm_pkg::S_IDLE;
         strobe_ff   <= 1'b0;
         root_ff     <= '0;
         key_bits_ff <= 7'd32;
         default_ff  <= -17'sd1;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         root_ff   <= root_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               btlpm_pkg::REG_KEY_BITS:      key_bits_ff <= csr_write_data[6:0];
               btlpm_pkg::REG_DEFAULT_VALUE: default_ff  <= $signed(csr_write_data);
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      idx_ff    <= idx_in;
      prev_ff   <= prev_in;
      depth_ff  <= depth_in;
      len_ff    <= len_in;
      op_ff     <= op_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      best_ff   <= best_in;
      status_ff <= status_in;
      match_ff  <= match_in;
   end

   assign busy            = state_ff != btlpm_pkg::S_IDLE;
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_match_value = match_ff;

endmodule
`default_nettype wire

// ----- rtl/btlpm_node_ram.sv -----
// Node memory: one write port, one registered read port.
`default_nettype none
module btlpm_node_ram (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire btlpm_pkg::node_idx_type wr_addr,
   input  wire btlpm_pkg::node_type     wr_data,
   input  wire logic                    rd_en,
   input  wire btlpm_pkg::node_idx_type rd_addr,
   output btlpm_pkg::node_type          rd_data
);

   btlpm_pkg::node_type mem [btlpm_pkg::NODES];
   btlpm_pkg::node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/btlpm_free_list.sv -----
// Free node stack with a low-water mark standing in for the reset fill.
`default_nettype none
module btlpm_free_list (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    pop,
   input  wire logic                    push,
   input  wire btlpm_pkg::node_idx_type push_data,
   output btlpm_pkg::node_idx_type      pop_data,
   output logic [btlpm_pkg::COUNT_BITS-1:0] count
);

   btlpm_pkg::node_idx_type mem [btlpm_pkg::NODES];
   logic [btlpm_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [btlpm_pkg::COUNT_BITS-1:0] mark_ff, mark_in;
   logic [btlpm_pkg::COUNT_BITS-1:0] pop_addr;
   btlpm_pkg::node_idx_type          rd_ff, init_ff;
   logic                             use_init_ff;

   assign pop_addr = count_ff - 1'b1;

   always_comb begin
      count_in = count_ff;
      mark_in  = mark_ff;
      if (pop) begin
         count_in = pop_addr;
         if (pop_addr < mark_ff) begin
            mark_in = pop_addr;
         end
      end else if (push) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= btlpm_pkg::COUNT_BITS'(btlpm_pkg::NODES - 1);
         mark_ff  <= btlpm_pkg::COUNT_BITS'(btlpm_pkg::NODES - 1);
      end else begin
         count_ff <= count_in;
         mark_ff  <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !pop) begin
         mem[count_ff[btlpm_pkg::NODE_BITS-1:0]] <= push_data;
      end
      if (pop) begin
         rd_ff       <= mem[pop_addr[btlpm_pkg::NODE_BITS-1:0]];
         init_ff     <= ~pop_addr[btlpm_pkg::NODE_BITS-1:0];
         use_init_ff <= pop_addr < mark_ff;
      end
   end

   assign pop_data = use_init_ff ? init_ff : rd_ff;
   assign count    = count_ff;

endmodule
`default_nettype wire
